[hw/rtl/bblru_pkg.sv]
// ----------------------------------------------------------------------------
// bblru_pkg
// Shared types and constants for the byte-budget LRU cache directory.
// ----------------------------------------------------------------------------
package bblru_pkg;

    localparam int ENTRIES   = 16;
    localparam int KEY_BITS  = 64;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W    = IDX_W;
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int BUDGET_W  = 36;
    localparam int SIZE_W    = 32;

    localparam logic [BUDGET_W-1:0] BUDGET_RESET = BUDGET_W'(268435456);

    localparam logic [1:0] KIND_PROBE = 2'd0;
    localparam logic [1:0] KIND_GET   = 2'd1;
    localparam logic [1:0] KIND_PUT   = 2'd2;

    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_NOT_FOUND = 3'd1;
    localparam logic [2:0] STATUS_CANCELLED = 3'd2;
    localparam logic [2:0] STATUS_TOO_LARGE = 3'd3;
    localparam logic [2:0] STATUS_OFFSET    = 3'd4;

    typedef struct packed {
        logic [1:0]        kind;
        logic [63:0]       key;
        logic [SIZE_W-1:0] entry_size;
        logic [SIZE_W-1:0] read_offset;
        logic [SIZE_W-1:0] read_length;
        logic              cancelled;
    } req_t;

    typedef struct packed {
        logic [2:0]          status;
        logic                hit;
        logic [SIZE_W-1:0]   copy_length;
        logic [IDX_W-1:0]    slot;
        logic [CNT_W-1:0]    evicted_count;
        logic [BUDGET_W-1:0] bytes_in_use;
    } rsp_t;

    // Command broadcast to every cell.
    typedef struct packed {
        logic              touch;
        logic              evict;
        logic              insert;
        logic [RANK_W-1:0] rank;
        logic [SIZE_W-1:0] bytes;
    } cell_cmd_t;

    // Accumulator handed from one cell to the next.
    typedef struct packed {
        logic              free_seen;
        logic [IDX_W-1:0]  ins_idx;
        logic              hit;
        logic [IDX_W-1:0]  hit_idx;
        logic [SIZE_W-1:0] hit_bytes;
        logic [RANK_W-1:0] hit_rank;
        logic [SIZE_W-1:0] tail_bytes;
    } chain_t;

endpackage

[hw/rtl/byte_budget_lru_cache_directory.sv]
// ----------------------------------------------------------------------------
// byte_budget_lru_cache_directory
// LRU cache directory with a byte budget, built as a row of slot cells.
// ----------------------------------------------------------------------------
// Requests arrive as beats on the req channel (req_valid / req_stall) and each
// one yields exactly one response beat on the rsp channel (rsp_valid /
// rsp_stall). A request is a probe, a get that refreshes recency, or a put.
// The user must write the budget register through cfg_we / cfg_data only while
// the block is idle; the block does not enforce this. It resets to 2^28 bytes.
// Every request walks through lookup, action and completion steps before its
// response register is loaded, and a new request is taken only after the
// completion step returns to idle. A put of a new key that fits the budget
// also passes through an eviction step, repeated while room is still needed
// and removing one tail entry each time, and then an insert step. The broadcast
// to the cell row and the reduction chain through the cells carry one
// directory operation per cycle.
// A new request is taken only in the idle step, but the response register is
// separate, so a request can be accepted while the previous response is still
// stalled. If the receiver stalls, the finished response waits in the
// completion step until the register drains. Reset clears all valid bits,
// ranks, the byte total and the budget back to its default.
// ----------------------------------------------------------------------------
module byte_budget_lru_cache_directory (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [bblru_pkg::BUDGET_W-1:0]       cfg_data,
    input  logic                                 req_valid,
    output logic                                 req_stall,
    input  bblru_pkg::req_t                      req,
    output logic                                 rsp_valid,
    input  logic                                 rsp_stall,
    output bblru_pkg::rsp_t                      rsp
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_LOOK   = 6'b000010,
        ST_ACT    = 6'b000100,
        ST_EVICT  = 6'b001000,
        ST_INSERT = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t                              state_reg, state_next;
    logic [bblru_pkg::BUDGET_W-1:0]      budget_reg;
    logic [bblru_pkg::BUDGET_W-1:0]      total_reg;
    logic [bblru_pkg::CNT_W-1:0]         count_reg;
    bblru_pkg::req_t                     req_reg;
    bblru_pkg::rsp_t                     res_reg;
    bblru_pkg::rsp_t                     rsp_reg;
    logic                                rsp_valid_reg;
    logic                                hit_reg;
    logic [bblru_pkg::SIZE_W-1:0]        hit_bytes_reg;
    logic [bblru_pkg::RANK_W-1:0]        hit_rank_reg;

    bblru_pkg::cell_cmd_t                cmd;
    bblru_pkg::chain_t                   link [0:bblru_pkg::ENTRIES];
    logic [bblru_pkg::ENTRIES-1:0]       occ;
    logic                                req_fire;
    logic                                done_fire;
    logic                                need_evict;
    logic [bblru_pkg::BUDGET_W:0]        demand;

    assign req_fire  = req_valid && !req_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign done_fire = (state_reg == ST_DONE) && (!rsp_valid_reg || !rsp_stall);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Room is needed when the new size overflows the budget or every slot is taken.
    assign demand     = {1'b0, total_reg} + (bblru_pkg::BUDGET_W + 1)'(req_reg.entry_size);
    assign need_evict = (demand > {1'b0, budget_reg})
                     || (count_reg == bblru_pkg::CNT_W'(bblru_pkg::ENTRIES));

    always_comb
    begin
        cmd        = '0;
        cmd.bytes  = req_reg.entry_size;
        cmd.touch  = (state_reg == ST_ACT) && (req_reg.kind == bblru_pkg::KIND_GET)
                  && hit_reg;
        cmd.evict  = (state_reg == ST_EVICT) && need_evict;
        cmd.insert = (state_reg == ST_INSERT);
        if (state_reg == ST_EVICT)
            cmd.rank = bblru_pkg::RANK_W'(count_reg - 1'b1);
        else
            cmd.rank = hit_rank_reg;
    end

    assign link[0] = '0;

    for (genvar i = 0; i < bblru_pkg::ENTRIES; i++)
    begin : g_cell
        bblru_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .index      (bblru_pkg::IDX_W'(i)),
            .lookup_key (req_reg.key[bblru_pkg::KEY_BITS-1:0]),
            .cmd        (cmd),
            .chain_in   (link[i]),
            .chain_out  (link[i+1]),
            .occupied   (occ[i])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (req_fire) state_next = ST_LOOK;
            ST_LOOK:   state_next = ST_ACT;
            ST_ACT:
            begin
                if (req_reg.kind == bblru_pkg::KIND_PUT && !hit_reg
                    && ({4'b0, req_reg.entry_size} <= budget_reg))
                    state_next = ST_EVICT;
                else
                    state_next = ST_DONE;
            end
            ST_EVICT:  if (!need_evict) state_next = ST_INSERT;
            ST_INSERT: state_next = ST_DONE;
            ST_DONE:   if (done_fire) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            budget_reg    <= bblru_pkg::BUDGET_RESET;
            total_reg     <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                budget_reg <= cfg_data;
            if (cmd.evict)
            begin
                total_reg <= total_reg - bblru_pkg::BUDGET_W'(link[bblru_pkg::ENTRIES].tail_bytes);
                count_reg <= count_reg - 1'b1;
            end
            else if (cmd.insert)
            begin
                total_reg <= total_reg + bblru_pkg::BUDGET_W'(req_reg.entry_size);
                count_reg <= count_reg + 1'b1;
            end
            if (done_fire)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
            req_reg <= req;
        if (state_reg == ST_LOOK)
        begin
            hit_bytes_reg <= link[bblru_pkg::ENTRIES].hit_bytes;
            hit_rank_reg  <= link[bblru_pkg::ENTRIES].hit_rank;
            hit_reg       <= link[bblru_pkg::ENTRIES].hit;
            res_reg       <= '{status:        bblru_pkg::STATUS_OK,
                               hit:           link[bblru_pkg::ENTRIES].hit,
                               copy_length:   '0,
                               slot:          link[bblru_pkg::ENTRIES].hit_idx,
                               evicted_count: '0,
                               bytes_in_use:  '0};
        end
        if (state_reg == ST_ACT)
        begin
            case (req_reg.kind)
                bblru_pkg::KIND_GET:
                begin
                    if (!hit_reg)
                        res_reg.status <= bblru_pkg::STATUS_NOT_FOUND;
                    else if (req_reg.cancelled)
                        res_reg.status <= bblru_pkg::STATUS_CANCELLED;
                    else if (req_reg.read_offset > hit_bytes_reg)
                        res_reg.status <= bblru_pkg::STATUS_OFFSET;
                    else
                        res_reg.copy_length <= (req_reg.read_length < hit_bytes_reg)
                                             ? req_reg.read_length : hit_bytes_reg;
                end
                bblru_pkg::KIND_PUT:
                begin
                    if (!hit_reg && ({4'b0, req_reg.entry_size} > budget_reg))
                        res_reg.status <= bblru_pkg::STATUS_TOO_LARGE;
                end
                default:
                begin
                    if (!hit_reg)
                        res_reg.status <= bblru_pkg::STATUS_NOT_FOUND;
                end
            endcase
        end
        if (cmd.evict)
            res_reg.evicted_count <= res_reg.evicted_count + 1'b1;
        if (cmd.insert)
            res_reg.slot <= link[bblru_pkg::ENTRIES].ins_idx;
        if (done_fire)
        begin
            rsp_reg <= '{status:        res_reg.status,
                         hit:           res_reg.hit,
                         copy_length:   res_reg.copy_length,
                         slot:          res_reg.slot,
                         evicted_count: res_reg.evicted_count,
                         bytes_in_use:  total_reg};
        end
    end

    // The fill count tracks the number of occupied cells.
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == bblru_pkg::CNT_W'($countones(occ)))
        else $error("fill count disagrees with occupied cells");

    // An eviction always has a tail entry to remove.
    a_evict_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.evict |-> (count_reg != '0))
        else $error("eviction with an empty directory");

    // An insertion always finds a free cell.
    a_insert_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |-> (link[bblru_pkg::ENTRIES].free_seen && !need_evict))
        else $error("insertion without room");

    // A request moves the directory out of idle on the next cycle.
    a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg == ST_LOOK))
        else $error("accepted request did not start a lookup");

endmodule

[hw/rtl/bblru_cell.sv]
// ----------------------------------------------------------------------------
// bblru_cell
// One directory slot: valid bit, key, byte size and recency rank.
// ----------------------------------------------------------------------------
module bblru_cell (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [bblru_pkg::IDX_W-1:0]          index,
    input  logic [bblru_pkg::KEY_BITS-1:0]       lookup_key,
    input  bblru_pkg::cell_cmd_t                 cmd,
    input  bblru_pkg::chain_t                    chain_in,
    output bblru_pkg::chain_t                    chain_out,
    output logic                                 occupied
);

    logic                                valid_reg;
    logic [bblru_pkg::RANK_W-1:0]        rank_reg;
    logic [bblru_pkg::KEY_BITS-1:0]      key_reg;
    logic [bblru_pkg::SIZE_W-1:0]        bytes_reg;
    logic                                match;
    logic                                is_tail;
    logic                                mine_free;

    assign match     = valid_reg && (key_reg == lookup_key);
    assign is_tail   = valid_reg && (rank_reg == cmd.rank);
    assign mine_free = !valid_reg && !chain_in.free_seen;
    assign occupied  = valid_reg;

    always_comb
    begin
        chain_out            = chain_in;
        chain_out.free_seen  = chain_in.free_seen | !valid_reg;
        chain_out.ins_idx    = chain_in.ins_idx | (mine_free ? index : '0);
        chain_out.hit        = chain_in.hit | match;
        chain_out.hit_idx    = chain_in.hit_idx | (match ? index : '0);
        chain_out.hit_bytes  = chain_in.hit_bytes | (match ? bytes_reg : '0);
        chain_out.hit_rank   = chain_in.hit_rank | (match ? rank_reg : '0);
        chain_out.tail_bytes = chain_in.tail_bytes | (is_tail ? bytes_reg : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else if (cmd.touch)
        begin
            if (match)
                rank_reg <= '0;
            else if (valid_reg && rank_reg < cmd.rank)
                rank_reg <= rank_reg + 1'b1;
        end
        else if (cmd.evict)
        begin
            if (is_tail)
            begin
                valid_reg <= 1'b0;
                rank_reg  <= '0;
            end
        end
        else if (cmd.insert)
        begin
            if (mine_free)
            begin
                valid_reg <= 1'b1;
                rank_reg  <= '0;
            end
            else if (valid_reg)
                rank_reg <= rank_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.insert && mine_free)
        begin
            key_reg   <= lookup_key;
            bytes_reg <= cmd.bytes;
        end
    end

endmodule
